// ===== hw/rtl/idrfs_pkg.sv =====
package idrfs_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int FREE_DEPTH_DEF = 16;
    localparam int TAG_BITS_DEF   = 32;

    localparam int TAG_IN_W  = 32;
    localparam int ID_PORT_W = 10;
    localparam int MAX_IDS_W = 11;

    localparam logic [MAX_IDS_W-1:0] MAX_IDS_RST = 11'd1024;

    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_REMOVE_ID  = 2'd1,
        OP_REMOVE_TAG = 2'd2,
        OP_CLEAR      = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_ZERO_TAG  = 2'd3
    } status_t;

    typedef struct packed {
        logic    capture;
        logic    clr_init;
        logic    clr_step;
        logic    fc_clear;
        logic    pop;
        logic    rd_eid;
        logic    scan_init;
        logic    scan_step;
        logic    scan_push;
        logic    free_cur;
        logic    free_hit;
        logic    write_tag;
        logic    res_valid;
        logic    res_id;
        status_t res_status;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    tag_zero;
        logic    eid_ok;
        logic    fc_zero;
        logic    fc_full;
        logic    top_ok;
        logic    rd_zero;
        logic    rd_match;
        logic    scan_end;
        logic    clr_last;
    } stat_t;

endpackage

// ===== hw/rtl/idrfs_ctrl.sv =====
module idrfs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output idrfs_pkg::cmd_t   cmd,
    input  idrfs_pkg::stat_t  st
);
    import idrfs_pkg::*;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_POP,
        S_POP_CHK,
        S_SCAN_FREE,
        S_RID_CHK,
        S_SCAN_TAG,
        S_CLEAR
    } state_t;

    state_t state_reg, state_next;
    logic   refilled_reg, refilled_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            refilled_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            refilled_reg <= refilled_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd           = '0;
        cmd.res_status = ST_OK;
        state_next    = state_reg;
        refilled_next = refilled_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (st.op)
                    OP_REGISTER:
                    begin
                        if (st.tag_zero)
                        begin
                            cmd.res_valid  = 1'b1;
                            cmd.res_status = ST_ZERO_TAG;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            refilled_next = 1'b0;
                            state_next    = S_POP;
                        end
                    end
                    OP_REMOVE_ID:
                    begin
                        if (!st.eid_ok)
                        begin
                            cmd.res_valid  = 1'b1;
                            cmd.res_status = ST_NOT_FOUND;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_eid = 1'b1;
                            state_next = S_RID_CHK;
                        end
                    end
                    OP_REMOVE_TAG:
                    begin
                        if (st.tag_zero)
                        begin
                            cmd.res_valid  = 1'b1;
                            cmd.res_status = ST_ZERO_TAG;
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN_TAG;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.clr_init = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_POP:
            begin
                if (st.fc_zero)
                begin
                    if (refilled_reg)
                    begin
                        cmd.res_valid  = 1'b1;
                        cmd.res_status = ST_FULL;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        refilled_next = 1'b1;
                        state_next    = S_SCAN_FREE;
                    end
                end
                else
                begin
                    // drop stale ids right here, check table entry of good ones
                    cmd.pop = 1'b1;
                    if (st.top_ok)
                        state_next = S_POP_CHK;
                end
            end
            S_POP_CHK:
            begin
                if (st.rd_zero)
                begin
                    cmd.write_tag = 1'b1;
                    cmd.res_valid = 1'b1;
                    cmd.res_id    = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_SCAN_FREE:
            begin
                cmd.scan_step = 1'b1;
                cmd.scan_push = 1'b1;
                if (st.fc_full || st.scan_end)
                    state_next = S_POP;
            end
            S_RID_CHK:
            begin
                cmd.res_valid = 1'b1;
                if (st.rd_zero)
                    cmd.res_status = ST_NOT_FOUND;
                else
                    cmd.free_cur = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN_TAG:
            begin
                cmd.scan_step = 1'b1;
                if (st.rd_match)
                begin
                    cmd.free_hit  = 1'b1;
                    cmd.res_valid = 1'b1;
                    state_next    = S_IDLE;
                end
                else if (st.scan_end)
                begin
                    cmd.res_valid  = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    state_next     = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (st.clr_last)
                begin
                    cmd.fc_clear  = 1'b1;
                    cmd.res_valid = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/idrfs_dp.sv =====
module idrfs_dp
#(
    parameter int CAPACITY   = idrfs_pkg::CAPACITY_DEF,
    parameter int FREE_DEPTH = idrfs_pkg::FREE_DEPTH_DEF,
    parameter int TAG_BITS   = idrfs_pkg::TAG_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [1:0]                       opcode,
    input  logic [idrfs_pkg::TAG_IN_W-1:0]   tag_value,
    input  logic [idrfs_pkg::ID_PORT_W-1:0]  entry_id,
    input  logic                             max_ids_we,
    input  logic [idrfs_pkg::MAX_IDS_W-1:0]  max_ids_wdata,
    input  idrfs_pkg::cmd_t                  cmd,
    output idrfs_pkg::stat_t                 st,
    output logic                             done,
    output logic [idrfs_pkg::ID_PORT_W-1:0]  assigned_id,
    output logic [1:0]                       status
);
    import idrfs_pkg::*;

    localparam int ID_W  = $clog2(CAPACITY);
    localparam int LIM_W = (ID_W + 1 > MAX_IDS_W) ? ID_W + 1 : MAX_IDS_W;
    localparam int FC_W  = $clog2(FREE_DEPTH);
    localparam logic [FC_W-1:0]  FC_TOP = FC_W'(FREE_DEPTH - 1);
    localparam logic [LIM_W-1:0] CAP_L  = LIM_W'(CAPACITY);
    localparam logic [LIM_W-1:0] LIM_LO = LIM_W'(2);

    logic [MAX_IDS_W-1:0] max_ids_reg;
    opcode_t              op_reg;
    logic [TAG_BITS-1:0]  tag_reg;
    logic [ID_PORT_W-1:0] eid_reg;
    logic [LIM_W-1:0]     lim_reg;
    logic [ID_W-1:0]      cur_id_reg;
    logic [LIM_W-1:0]     addr_reg;
    logic                 rd_valid_reg;
    logic [ID_W-1:0]      rd_addr_reg;
    logic [TAG_BITS-1:0]  rdata_reg;
    logic [FC_W-1:0]      fc_reg;
    logic [ID_W-1:0]      stack_reg [FREE_DEPTH];
    logic [TAG_BITS-1:0]  tag_mem [CAPACITY];
    logic                 done_reg;
    logic [ID_PORT_W-1:0] aid_reg;
    status_t              status_reg;

    logic [LIM_W-1:0]     mx;
    logic [LIM_W-1:0]     lim_now;
    logic [ID_W-1:0]      top;
    logic                 issue;
    logic                 rd_en;
    logic [ID_W-1:0]      raddr;
    logic                 we;
    logic [ID_W-1:0]      waddr;
    logic [TAG_BITS-1:0]  wdata;
    logic                 push;
    logic [ID_W-1:0]      push_id;

    always_comb
    begin
        mx = LIM_W'(max_ids_reg);
        if (mx < LIM_LO)
            lim_now = LIM_LO;
        else if (mx > CAP_L)
            lim_now = CAP_L;
        else
            lim_now = mx;
    end

    assign top   = stack_reg[fc_reg - 1'b1];
    assign issue = (addr_reg < lim_reg);

    always_comb
    begin
        st.op       = op_reg;
        st.tag_zero = (tag_reg == '0);
        st.eid_ok   = (eid_reg != '0) && (LIM_W'(eid_reg) < lim_reg);
        st.fc_zero  = (fc_reg == '0);
        st.fc_full  = (fc_reg == FC_TOP);
        st.top_ok   = (top != '0) && (LIM_W'(top) < lim_reg);
        st.rd_zero  = (rdata_reg == '0);
        st.rd_match = rd_valid_reg && (rdata_reg == tag_reg);
        st.scan_end = !issue && !rd_valid_reg;
        st.clr_last = (addr_reg == CAP_L - 1'b1);
    end

    always_comb
    begin
        rd_en = 1'b0;
        raddr = addr_reg[ID_W-1:0];
        if (cmd.pop)
        begin
            rd_en = 1'b1;
            raddr = top;
        end
        else if (cmd.rd_eid)
        begin
            rd_en = 1'b1;
            raddr = ID_W'(eid_reg);
        end
        else if (cmd.scan_step && issue)
        begin
            rd_en = 1'b1;
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = cur_id_reg;
        wdata = '0;
        if (cmd.clr_step)
        begin
            we    = 1'b1;
            waddr = addr_reg[ID_W-1:0];
        end
        else if (cmd.write_tag)
        begin
            we    = 1'b1;
            wdata = tag_reg;
        end
        else if (cmd.free_cur)
        begin
            we = 1'b1;
        end
        else if (cmd.free_hit)
        begin
            we    = 1'b1;
            waddr = rd_addr_reg;
        end
    end

    always_comb
    begin
        push    = 1'b0;
        push_id = rd_addr_reg;
        if (cmd.free_cur)
        begin
            push    = 1'b1;
            push_id = cur_id_reg;
        end
        else if (cmd.free_hit)
        begin
            push = 1'b1;
        end
        else if (cmd.scan_push && rd_valid_reg && (rdata_reg == '0))
        begin
            push = 1'b1;
        end
        // hold one slot back, as the stack never fills completely
        if (fc_reg == FC_TOP)
            push = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= tag_mem[raddr];
        if (we)
            tag_mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            stack_reg[fc_reg] <= push_id;
        if (cmd.capture)
        begin
            op_reg  <= opcode_t'(opcode);
            tag_reg <= TAG_BITS'(tag_value);
            eid_reg <= entry_id;
            lim_reg <= lim_now;
        end
        if (cmd.pop)
            cur_id_reg <= top;
        else if (cmd.rd_eid)
            cur_id_reg <= ID_W'(eid_reg);
        rd_addr_reg <= addr_reg[ID_W-1:0];
        if (cmd.res_valid)
        begin
            aid_reg    <= cmd.res_id ? ID_PORT_W'(cur_id_reg) : '0;
            status_reg <= cmd.res_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_ids_reg  <= MAX_IDS_RST;
            fc_reg       <= '0;
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (max_ids_we)
                max_ids_reg <= max_ids_wdata;
            if (cmd.fc_clear)
                fc_reg <= '0;
            else if (cmd.pop)
                fc_reg <= fc_reg - 1'b1;
            else if (push)
                fc_reg <= fc_reg + 1'b1;
            if (cmd.clr_init)
                addr_reg <= '0;
            else if (cmd.scan_init)
                addr_reg <= LIM_W'(1);
            else if (cmd.clr_step || (cmd.scan_step && issue))
                addr_reg <= addr_reg + 1'b1;
            rd_valid_reg <= cmd.scan_step && issue && !cmd.scan_init;
            done_reg     <= cmd.res_valid;
        end
    end

    assign done        = done_reg;
    assign assigned_id = aid_reg;
    assign status      = status_reg;

endmodule

// ===== hw/rtl/id_registry_free_stack.sv =====
// Id allocator: a request (start while busy is low) registers a tag, removes by id or by
// tag, or clears the table; one result follows on done for a single cycle and must be
// taken then, as the block cannot be held off. A register is served from the free-id
// stack, dropping each stale id that it pops; an empty stack triggers a refill scan of
// one table entry per cycle. Remove by tag reads one table entry per cycle; clear
// sweeps every table entry to empty. After reset, busy stays high while the tag table
// is swept to empty.
module id_registry_free_stack
#(
    parameter int CAPACITY   = idrfs_pkg::CAPACITY_DEF,
    parameter int FREE_DEPTH = idrfs_pkg::FREE_DEPTH_DEF,
    parameter int TAG_BITS   = idrfs_pkg::TAG_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       opcode,
    input  logic [idrfs_pkg::TAG_IN_W-1:0]   tag_value,
    input  logic [idrfs_pkg::ID_PORT_W-1:0]  entry_id,
    output logic                             done,
    output logic [idrfs_pkg::ID_PORT_W-1:0]  assigned_id,
    output logic [1:0]                       status,
    input  logic                             max_ids_we,
    input  logic [idrfs_pkg::MAX_IDS_W-1:0]  max_ids_wdata
);
    import idrfs_pkg::*;

    cmd_t  cmd;
    stat_t st;

    idrfs_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .st    (st)
    );

    idrfs_dp
    #(
        .CAPACITY   (CAPACITY),
        .FREE_DEPTH (FREE_DEPTH),
        .TAG_BITS   (TAG_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .opcode        (opcode),
        .tag_value     (tag_value),
        .entry_id      (entry_id),
        .max_ids_we    (max_ids_we),
        .max_ids_wdata (max_ids_wdata),
        .cmd           (cmd),
        .st            (st),
        .done          (done),
        .assigned_id   (assigned_id),
        .status        (status)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_id_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && (assigned_id != '0) |-> status == ST_OK)
        else $error("id handed out with a failing status");

endmodule
